@@ hdl/jve_pkg.sv @@
`timescale 1ns / 1ps

package jve_pkg;

    localparam int JVE_JOINTS     = 6;
    localparam int JVE_MAX_WINDOW = 16;

    localparam int STAMP_W    = 48;
    localparam int POS_W      = 32;
    localparam int VEL_W      = 32;
    localparam int WINDOW_W   = 5;
    localparam int LIMIT_W    = 31;
    localparam int WEIGHT_W   = 17;
    localparam int GAP_W      = 24;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam int MAG_W     = POS_W;
    localparam int SCALE_W   = 20;
    localparam int PROD_W    = MAG_W + SCALE_W;
    localparam int QUO_W     = LIMIT_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int FRAC_W    = 16;
    localparam int BLEND_W   = (VEL_W + 1) + (WEIGHT_W + 1);

    localparam logic [SCALE_W-1:0]  US_PER_S = SCALE_W'(1000000);
    localparam logic [WEIGHT_W-1:0] Q16_ONE  = WEIGHT_W'(65536);
    localparam int MIN_WINDOW = 3;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET  = WINDOW_W'(3);
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET   = LIMIT_W'(655360);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = WEIGHT_W'(65536);
    localparam logic [GAP_W-1:0]    MAX_GAP_RESET = GAP_W'(100000);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WINDOW  = 2'd0,
        REG_LIMIT   = 2'd1,
        REG_WEIGHT  = 2'd2,
        REG_MAX_GAP = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        LANE_HOLD,
        LANE_LOAD,
        LANE_CLEAR,
        LANE_MUL,
        LANE_PREP,
        LANE_DIV,
        LANE_CLAMP,
        LANE_BLEND,
        LANE_COMMIT
    } lane_op_t;

    typedef struct packed {
        lane_op_t              op;
        logic                  primed;
        logic [GAP_W-1:0]      gap;
        logic [LIMIT_W-1:0]    limit;
        logic [WEIGHT_W-1:0]   weight;
    } lane_ctrl_t;

    typedef struct packed {
        logic load;
        logic est_valid;
    } merge_ctrl_t;

endpackage

@@ hdl/jve_cfg_if.sv @@
`timescale 1ns / 1ps

interface jve_cfg_if import jve_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/jve_sample_if.sv @@
`timescale 1ns / 1ps

interface jve_sample_if import jve_pkg::*; #(
    parameter int JOINTS = JVE_JOINTS
);
    logic                                valid;
    logic                                ready;
    logic [STAMP_W-1:0]                  stamp_us;
    logic                                sample_ok;
    logic signed [JOINTS-1:0][POS_W-1:0] pos;

    modport source (output valid, output stamp_us, output sample_ok, output pos, input ready);
    modport sink   (input valid, input stamp_us, input sample_ok, input pos, output ready);
endinterface

@@ hdl/jve_estimate_if.sv @@
`timescale 1ns / 1ps

interface jve_estimate_if import jve_pkg::*; #(
    parameter int JOINTS = JVE_JOINTS
);
    logic                                valid;
    logic                                ready;
    logic                                estimate_valid;
    logic signed [JOINTS-1:0][VEL_W-1:0] vel;

    modport source (output valid, output estimate_valid, output vel, input ready);
    modport sink   (input valid, input estimate_valid, input vel, output ready);
endinterface

@@ hdl/joint_velocity_estimator_core.sv @@
`timescale 1ns / 1ps

// Finite-difference joint velocity estimator with clamp and exponential smoothing.
// Each sample request carries a stamp and JOINTS positions; one lane per joint
// forms (pos - last_pos) * 1e6 / gap with a restoring divider that resolves one
// quotient bit per cycle. A sample that yields a valid estimate passes through the
// scale multiply, divider setup, divide steps, clamp, blend multiply and commit
// before its result moves into the output register; a sample that is rejected or
// still inside the warm-up window skips those steps. A new sample is taken once
// the previous result has moved into the output register, which holds it until
// the sink takes it. Configuration writes are always ready and should be issued
// only while no sample is in flight.
module joint_velocity_estimator_core import jve_pkg::*; #(
    parameter int JOINTS     = JVE_JOINTS,
    parameter int MAX_WINDOW = JVE_MAX_WINDOW
) (
    input  logic           clk,
    input  logic           rst_n,
    jve_cfg_if.sink        cfg,
    jve_sample_if.sink     samples,
    jve_estimate_if.source estimates
);

    lane_ctrl_t                          lane_ctrl;
    merge_ctrl_t                         merge_ctrl;
    logic                                slot_free;
    logic signed [JOINTS-1:0][VEL_W-1:0] lane_vel;

    jve_ctrl #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .samples    (samples),
        .slot_free  (slot_free),
        .lane_ctrl  (lane_ctrl),
        .merge_ctrl (merge_ctrl)
    );

    for (genvar g = 0; g < JOINTS; g++)
    begin : g_lane
        jve_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (lane_ctrl),
            .pos   (samples.pos[g]),
            .vel   (lane_vel[g])
        );
    end

    jve_merge #(
        .JOINTS (JOINTS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .merge_ctrl (merge_ctrl),
        .lane_vel   (lane_vel),
        .slot_free  (slot_free),
        .estimates  (estimates)
    );

endmodule

@@ hdl/jve_lane.sv @@
`timescale 1ns / 1ps

module jve_lane import jve_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lane_ctrl_t              ctrl,
    input  logic signed [POS_W-1:0] pos,
    output logic signed [VEL_W-1:0] vel
);

    logic signed [POS_W-1:0]   last_pos_reg;
    logic                      neg_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic [PROD_W-1:0]         dividend_reg;
    logic [GAP_W-1:0]          rem_reg;
    logic [QUO_W-1:0]          quo_reg;
    logic                      ovf_reg;
    logic signed [VEL_W-1:0]   raw_reg;
    logic signed [BLEND_W-1:0] blend_reg;
    logic signed [VEL_W-1:0]   filt_reg;

    logic signed [POS_W:0]     diff;
    logic [POS_W:0]            diff_neg;
    logic [MAG_W-1:0]          diff_mag;
    logic [GAP_W-1:0]          dividend_hi;
    logic [GAP_W:0]            trial;
    logic [GAP_W:0]            gap_ext;
    logic [GAP_W:0]            trial_sub;
    logic                      trial_ge;
    logic [QUO_W-1:0]          mag_clamped;
    logic signed [VEL_W-1:0]   raw_pos;
    logic signed [VEL_W-1:0]   raw_next;
    logic signed [VEL_W:0]     delta;
    logic signed [WEIGHT_W:0]  weight_s;
    logic signed [BLEND_W-1:0] blend_sum;

    always_comb
    begin
        diff        = $signed({pos[POS_W-1], pos}) - $signed({last_pos_reg[POS_W-1], last_pos_reg});
        diff_neg    = -diff;
        diff_mag    = diff[POS_W] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];

        dividend_hi = GAP_W'(dividend_reg[PROD_W-1:QUO_W]);
        trial       = {rem_reg, quo_reg[QUO_W-1]};
        gap_ext     = {1'b0, ctrl.gap};
        trial_ge    = trial >= gap_ext;
        trial_sub   = trial - gap_ext;

        mag_clamped = (ovf_reg || (quo_reg > ctrl.limit)) ? ctrl.limit : quo_reg;
        raw_pos     = $signed({1'b0, mag_clamped});
        raw_next    = neg_reg ? -raw_pos : raw_pos;

        delta       = $signed({raw_reg[VEL_W-1], raw_reg}) - $signed({filt_reg[VEL_W-1], filt_reg});
        weight_s    = $signed({1'b0, ctrl.weight});
        blend_sum   = BLEND_W'(filt_reg) + (blend_reg >>> FRAC_W);
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            LANE_LOAD:
            begin
                last_pos_reg <= pos;
                neg_reg      <= diff[POS_W];
                mag_reg      <= diff_mag;
            end
            LANE_MUL:
            begin
                dividend_reg <= mag_reg * US_PER_S;
            end
            LANE_PREP:
            begin
                ovf_reg <= dividend_hi >= ctrl.gap;
                rem_reg <= dividend_hi;
                quo_reg <= dividend_reg[QUO_W-1:0];
            end
            LANE_DIV:
            begin
                rem_reg <= trial_ge ? trial_sub[GAP_W-1:0] : trial[GAP_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], trial_ge};
            end
            LANE_CLAMP:
            begin
                raw_reg <= raw_next;
            end
            LANE_BLEND:
            begin
                blend_reg <= delta * weight_s;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg <= '0;
        end
        else if (ctrl.op == LANE_CLEAR)
        begin
            filt_reg <= '0;
        end
        else if (ctrl.op == LANE_COMMIT)
        begin
            filt_reg <= ctrl.primed ? blend_sum[VEL_W-1:0] : raw_reg;
        end
    end

    assign vel = filt_reg;

endmodule

@@ hdl/jve_ctrl.sv @@
`timescale 1ns / 1ps

module jve_ctrl import jve_pkg::*; #(
    parameter int MAX_WINDOW = JVE_MAX_WINDOW
) (
    input  logic         clk,
    input  logic         rst_n,
    jve_cfg_if.sink      cfg,
    jve_sample_if.sink   samples,
    input  logic         slot_free,
    output lane_ctrl_t   lane_ctrl,
    output merge_ctrl_t  merge_ctrl
);

    localparam int COUNT_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W   = (COUNT_W > WINDOW_W) ? COUNT_W : WINDOW_W;
    localparam int STEP_W  = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_PREP,
        S_DIV,
        S_CLAMP,
        S_BLEND,
        S_COMMIT,
        S_FINISH
    } state_t;

    state_t               state_reg;
    logic [WINDOW_W-1:0]  window_reg;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [WEIGHT_W-1:0]  weight_reg;
    logic [GAP_W-1:0]     max_gap_reg;
    logic [STAMP_W-1:0]   last_stamp_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic                 primed_reg;
    logic [GAP_W-1:0]     gap_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 est_valid_reg;

    logic                 accept;
    logic [STAMP_W-1:0]   gap_full;
    logic                 bad;
    logic [CMP_W-1:0]     window_ext;
    logic [COUNT_W-1:0]   win;
    logic [COUNT_W:0]     count_plus;
    logic [COUNT_W-1:0]   count_next;
    logic                 ready_est;
    logic [WEIGHT_W-1:0]  weight_eff;

    assign cfg.ready     = 1'b1;
    assign samples.ready = (state_reg == S_IDLE);
    assign accept        = samples.valid && samples.ready;

    always_comb
    begin
        gap_full = samples.stamp_us - last_stamp_reg;
        bad      = (samples.stamp_us == '0) || !samples.sample_ok ||
                   ((count_reg != '0) &&
                    ((samples.stamp_us <= last_stamp_reg) ||
                     (gap_full > STAMP_W'(max_gap_reg))));

        window_ext = CMP_W'(window_reg);
        if (window_ext < CMP_W'(MIN_WINDOW))
        begin
            win = COUNT_W'(MIN_WINDOW);
        end
        else if (window_ext > CMP_W'(MAX_WINDOW))
        begin
            win = COUNT_W'(MAX_WINDOW);
        end
        else
        begin
            win = window_ext[COUNT_W-1:0];
        end

        count_plus = {1'b0, count_reg} + 1'b1;
        count_next = (count_reg < win) ? count_plus[COUNT_W-1:0] : count_reg;
        ready_est  = (count_plus >= {1'b0, win}) && (count_reg != '0);

        weight_eff = (weight_reg > Q16_ONE) ? Q16_ONE : weight_reg;
    end

    always_comb
    begin
        lane_ctrl.primed = primed_reg;
        lane_ctrl.gap    = gap_reg;
        lane_ctrl.limit  = limit_reg;
        lane_ctrl.weight = weight_eff;
        case (state_reg)
            S_IDLE:   lane_ctrl.op = !accept ? LANE_HOLD : (bad ? LANE_CLEAR : LANE_LOAD);
            S_MUL:    lane_ctrl.op = LANE_MUL;
            S_PREP:   lane_ctrl.op = LANE_PREP;
            S_DIV:    lane_ctrl.op = LANE_DIV;
            S_CLAMP:  lane_ctrl.op = LANE_CLAMP;
            S_BLEND:  lane_ctrl.op = LANE_BLEND;
            S_COMMIT: lane_ctrl.op = LANE_COMMIT;
            default:  lane_ctrl.op = LANE_HOLD;
        endcase

        merge_ctrl.load      = (state_reg == S_FINISH) && slot_free;
        merge_ctrl.est_valid = est_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            window_reg     <= WINDOW_RESET;
            limit_reg      <= LIMIT_RESET;
            weight_reg     <= WEIGHT_RESET;
            max_gap_reg    <= MAX_GAP_RESET;
            last_stamp_reg <= '0;
            count_reg      <= '0;
            primed_reg     <= 1'b0;
            gap_reg        <= '0;
            step_reg       <= '0;
            est_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_WINDOW:  window_reg  <= cfg.data[WINDOW_W-1:0];
                    REG_LIMIT:   limit_reg   <= cfg.data[LIMIT_W-1:0];
                    REG_WEIGHT:  weight_reg  <= cfg.data[WEIGHT_W-1:0];
                    REG_MAX_GAP: max_gap_reg <= cfg.data[GAP_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (bad)
                        begin
                            last_stamp_reg <= '0;
                            count_reg      <= '0;
                            primed_reg     <= 1'b0;
                            est_valid_reg  <= 1'b0;
                            state_reg      <= S_FINISH;
                        end
                        else
                        begin
                            last_stamp_reg <= samples.stamp_us;
                            count_reg      <= count_next;
                            gap_reg        <= gap_full[GAP_W-1:0];
                            est_valid_reg  <= ready_est;
                            state_reg      <= ready_est ? S_MUL : S_FINISH;
                        end
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (step_reg == STEP_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= S_CLAMP;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_CLAMP:
                begin
                    state_reg <= S_BLEND;
                end
                S_BLEND:
                begin
                    state_reg <= S_COMMIT;
                end
                S_COMMIT:
                begin
                    primed_reg <= 1'b1;
                    state_reg  <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hdl/jve_merge.sv @@
`timescale 1ns / 1ps

module jve_merge import jve_pkg::*; #(
    parameter int JOINTS = JVE_JOINTS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  merge_ctrl_t                         merge_ctrl,
    input  logic signed [JOINTS-1:0][VEL_W-1:0] lane_vel,
    output logic                                slot_free,
    jve_estimate_if.source                      estimates
);

    logic                                valid_reg;
    logic                                est_valid_reg;
    logic signed [JOINTS-1:0][VEL_W-1:0] vel_reg;

    assign slot_free = !valid_reg || estimates.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (merge_ctrl.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (estimates.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // zero the velocities of an invalid estimate
    always_ff @(posedge clk)
    begin
        if (merge_ctrl.load)
        begin
            est_valid_reg <= merge_ctrl.est_valid;
            vel_reg       <= merge_ctrl.est_valid ? lane_vel : '0;
        end
    end

    assign estimates.valid          = valid_reg;
    assign estimates.estimate_valid = est_valid_reg;
    assign estimates.vel            = vel_reg;

endmodule

@@ sim/jve_checker.sv @@
`timescale 1ns / 1ps

module jve_checker import jve_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    jve_cfg_if      cfg,
    jve_sample_if   samples,
    jve_estimate_if estimates,
    output int      mismatch_count,
    output int      estimates_due
);

    localparam int EXP_DEPTH = 4;

    typedef struct packed {
        logic                                est_valid;
        logic [JVE_JOINTS-1:0][VEL_W-1:0]    vel;
    } estimate_t;

    logic [WINDOW_W-1:0]     window_r;
    logic [LIMIT_W-1:0]      limit_r;
    logic [WEIGHT_W-1:0]     weight_r;
    logic [GAP_W-1:0]        gap_max_r;

    logic [STAMP_W-1:0]      prev_stamp;
    logic signed [POS_W-1:0] prev_pos [JVE_JOINTS];
    int unsigned             good_count;
    logic signed [VEL_W-1:0] smooth_vel [JVE_JOINTS];
    logic                    primed;

    estimate_t               expected_mem [EXP_DEPTH];
    int                      exp_wr;
    int                      exp_rd;

    function automatic void clear_history();
        prev_stamp = '0;
        good_count = 0;
        primed     = 1'b0;
        for (int j = 0; j < JVE_JOINTS; j++)
        begin
            prev_pos[j]   = '0;
            smooth_vel[j] = '0;
        end
    endfunction

    function automatic estimate_t predict_estimate(
        input logic [STAMP_W-1:0]                stamp,
        input logic                              ok,
        input logic [JVE_JOINTS-1:0][POS_W-1:0]  pos
    );
        estimate_t         e;
        longint unsigned   span;
        longint unsigned   mag;
        int unsigned       win;
        bit                ready;
        longint            diff;
        longint            raw;
        longint            est;
        longint            wt;
        longint            acc;
        e = '0;
        if (stamp == '0 || !ok)
        begin
            clear_history();
            return e;
        end
        span = 0;
        if (good_count > 0)
        begin
            if (stamp <= prev_stamp)
            begin
                clear_history();
                return e;
            end
            span = stamp - prev_stamp;
            if (span > gap_max_r)
            begin
                clear_history();
                return e;
            end
        end
        win = window_r;
        if (win < MIN_WINDOW)
            win = MIN_WINDOW;
        if (win > JVE_MAX_WINDOW)
            win = JVE_MAX_WINDOW;
        ready = (good_count + 1 >= win) && (good_count > 0);
        wt = (weight_r > Q16_ONE) ? longint'(Q16_ONE) : longint'(weight_r);
        if (ready)
        begin
            e.est_valid = 1'b1;
            for (int j = 0; j < JVE_JOINTS; j++)
            begin
                diff = longint'($signed(pos[j])) - longint'(prev_pos[j]);
                mag  = (diff < 0) ? -diff : diff;
                mag  = mag * 64'd1000000 / span;
                if (mag > limit_r)
                    mag = limit_r;
                raw = (diff < 0) ? -longint'(mag) : longint'(mag);
                if (!primed)
                    est = raw;
                else
                begin
                    acc = wt * raw + (longint'(65536) - wt) * longint'(smooth_vel[j]);
                    est = acc >>> 16;
                end
                smooth_vel[j] = VEL_W'(est);
                e.vel[j]      = VEL_W'(est);
            end
            primed = 1'b1;
        end
        prev_stamp = stamp;
        for (int j = 0; j < JVE_JOINTS; j++)
            prev_pos[j] = pos[j];
        if (good_count < win)
            good_count++;
        return e;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        estimate_t seen;
        estimate_t due;
        estimate_t pending;
        if (!rst_n)
        begin
            window_r  = WINDOW_RESET;
            limit_r   = LIMIT_RESET;
            weight_r  = WEIGHT_RESET;
            gap_max_r = MAX_GAP_RESET;
            clear_history();
            exp_wr = 0;
            exp_rd = 0;
            mismatch_count = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_reg_t'(cfg.index))
                    REG_WINDOW:  window_r  = cfg.data[WINDOW_W-1:0];
                    REG_LIMIT:   limit_r   = cfg.data[LIMIT_W-1:0];
                    REG_WEIGHT:  weight_r  = cfg.data[WEIGHT_W-1:0];
                    REG_MAX_GAP: gap_max_r = cfg.data[GAP_W-1:0];
                    default: ;
                endcase
            end
            if (samples.valid && samples.ready)
            begin
                pending = predict_estimate(samples.stamp_us, samples.sample_ok, samples.pos);
                if (exp_wr - exp_rd == EXP_DEPTH)
                begin
                    $error("too many requests outstanding");
                    mismatch_count++;
                end
                else
                begin
                    expected_mem[exp_wr % EXP_DEPTH] = pending;
                    exp_wr++;
                end
            end
            if (estimates.valid && estimates.ready)
            begin
                seen.est_valid = estimates.estimate_valid;
                seen.vel       = estimates.vel;
                if (exp_wr == exp_rd)
                begin
                    $error("estimate with no request outstanding");
                    mismatch_count++;
                end
                else
                begin
                    due = expected_mem[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (seen.est_valid !== due.est_valid)
                    begin
                        $error("estimate_valid: expected %0d, got %0d",
                               due.est_valid, seen.est_valid);
                        mismatch_count++;
                    end
                    for (int j = 0; j < JVE_JOINTS; j++)
                    begin
                        if (seen.vel[j] !== due.vel[j])
                        begin
                            $error("vel%0d: expected %0d, got %0d", j,
                                   $signed(due.vel[j]), $signed(seen.vel[j]));
                            mismatch_count++;
                        end
                    end
                end
            end
        end
        estimates_due = exp_wr - exp_rd;
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import jve_pkg::*;

    localparam int PHASE_COUNT    = 7;
    localparam int PHASE_SAMPLES  = 56;
    localparam int DRAIN_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic [POS_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0] POS_MIN = 32'h8000_0000;

    typedef logic [JVE_JOINTS-1:0][POS_W-1:0] pos_vec_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                idle_on;
    int                  mismatch_count;
    int                  estimates_due;
    int                  sent_samples;
    logic [WINDOW_W-1:0] cur_window;
    logic [GAP_W-1:0]    cur_gap_max;
    logic [STAMP_W-1:0]  track_stamp;
    pos_vec_t            track_pos;

    jve_cfg_if      cfg_bus ();
    jve_sample_if   sample_bus ();
    jve_estimate_if estimate_bus ();

    joint_velocity_estimator_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_bus),
        .samples   (sample_bus),
        .estimates (estimate_bus)
    );

    jve_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_bus),
        .samples        (sample_bus),
        .estimates      (estimate_bus),
        .mismatch_count (mismatch_count),
        .estimates_due  (estimates_due)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        estimate_bus.ready <= !idle_on || ($urandom_range(99) >= 26);

    function automatic logic [POS_W-1:0] pos_step();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 5)
            return POS_W'($urandom_range(4000)) - POS_W'(2000);
        if (pick < 8)
            return POS_W'($urandom_range(32'h0020_0000)) - POS_W'(32'h0010_0000);
        return $urandom;
    endfunction

    function automatic logic [STAMP_W-1:0] pick_gap();
        int unsigned      pick;
        logic [GAP_W-1:0] top;
        if (cur_gap_max == '0)
            return STAMP_W'($urandom_range(3, 1));
        pick = $urandom_range(9);
        if (pick == 0)
            return STAMP_W'(1);
        if (pick == 1)
            return STAMP_W'(cur_gap_max);
        top = (cur_gap_max > GAP_W'(20000)) ? GAP_W'(20000) : cur_gap_max;
        return STAMP_W'($urandom_range(top, 1));
    endfunction

    function automatic pos_vec_t random_pos();
        pos_vec_t p;
        for (int j = 0; j < JVE_JOINTS; j++)
            p[j] = $urandom;
        return p;
    endfunction

    function automatic logic [STAMP_W-1:0] random_stamp();
        return {16'($urandom_range(16'hFFFF)), 32'($urandom)};
    endfunction

    function automatic int unsigned eff_window();
        if (cur_window < MIN_WINDOW)
            return MIN_WINDOW;
        if (cur_window > JVE_MAX_WINDOW)
            return JVE_MAX_WINDOW;
        return cur_window;
    endfunction

    task automatic drive_sample(input logic [STAMP_W-1:0] st, input logic ok,
                                input pos_vec_t p);
        while (idle_on && $urandom_range(99) < 26)
        begin
            sample_bus.valid = 1'b0;
            @(negedge clk);
        end
        sample_bus.valid     = 1'b1;
        sample_bus.stamp_us  = st;
        sample_bus.sample_ok = ok;
        sample_bus.pos       = p;
        do
            @(posedge clk);
        while (!sample_bus.ready);
        @(negedge clk);
        sent_samples++;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        sample_bus.valid = 1'b0;
        while (estimates_due != 0)
            @(negedge clk);
    endtask

    task automatic apply_setting(input int ph);
        logic [CFG_DATA_W-1:0] w_win;
        logic [CFG_DATA_W-1:0] w_lim;
        logic [CFG_DATA_W-1:0] w_wt;
        logic [CFG_DATA_W-1:0] w_gap;
        case (ph)
            0:
            begin
                w_win = 16;
                w_lim = 32'h7FFF_FFFF;
                w_wt  = 1;
                w_gap = 32'h00FF_FFFF;
            end
            1:
            begin
                w_win = 0;
                w_lim = 1;
                w_wt  = 0;
                w_gap = 1;
            end
            2:
            begin
                w_win = 31;
                w_lim = 0;
                w_wt  = 32'h0001_FFFF;
                w_gap = 0;
            end
            3:
            begin
                w_win = 2;
                w_lim = $urandom_range(32'h0010_0000, 1);
                w_wt  = 32768;
                w_gap = 5000;
            end
            4:
            begin
                w_win = $urandom_range(16, 3);
                w_lim = $urandom_range(32'h7FFF_FFFF, 1);
                w_wt  = $urandom_range(65536, 1);
                w_gap = $urandom_range(200000, 1);
            end
            default:
            begin
                w_win = $urandom;
                w_lim = $urandom;
                w_wt  = $urandom;
                w_gap = $urandom;
            end
        endcase
        write_reg(REG_WINDOW, w_win);
        write_reg(REG_LIMIT, w_lim);
        write_reg(REG_WEIGHT, w_wt);
        write_reg(REG_MAX_GAP, w_gap);
        cfg_bus.valid = 1'b0;
        cur_window  = w_win[WINDOW_W-1:0];
        cur_gap_max = w_gap[GAP_W-1:0];
    endtask

    task automatic well_formed_run(input int unsigned len);
        logic [STAMP_W-1:0] st;
        pos_vec_t           p;
        track_stamp = random_stamp();
        if (track_stamp == '0)
            track_stamp = 1;
        track_pos = random_pos();
        repeat (len)
        begin
            if ($urandom_range(99) < 90)
            begin
                st = track_stamp + pick_gap();
                for (int j = 0; j < JVE_JOINTS; j++)
                    p[j] = track_pos[j] + pos_step();
                drive_sample(st, 1'b1, p);
                track_stamp = st;
                track_pos   = p;
            end
            else
            begin
                case ($urandom_range(4))
                    0: drive_sample('0, 1'b1, random_pos());
                    1: drive_sample(track_stamp + pick_gap(), 1'b0, random_pos());
                    2: drive_sample(track_stamp, 1'b1, random_pos());
                    3: drive_sample(track_stamp - STAMP_W'($urandom_range(100, 1)), 1'b1,
                                    random_pos());
                    default: drive_sample(track_stamp + STAMP_W'(cur_gap_max)
                                          + STAMP_W'($urandom_range(1000, 1)), 1'b1,
                                          random_pos());
                endcase
            end
        end
    endtask

    task automatic noise_burst(input int unsigned n);
        logic [STAMP_W-1:0] st;
        repeat (n)
        begin
            st = random_stamp();
            if ($urandom_range(7) == 0)
                st = '0;
            drive_sample(st, 1'($urandom_range(1)), random_pos());
        end
    endtask

    task automatic run_phase();
        int first;
        first = sent_samples;
        while (sent_samples - first < PHASE_SAMPLES)
        begin
            if ($urandom_range(99) < 80)
                well_formed_run(eff_window() + $urandom_range(12));
            else
                noise_burst($urandom_range(4, 1));
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        idle_on              = 1'b1;
        sent_samples         = 0;
        cur_window           = WINDOW_RESET;
        cur_gap_max          = MAX_GAP_RESET;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = REG_WINDOW;
        cfg_bus.data         = '0;
        sample_bus.valid     = 1'b0;
        sample_bus.stamp_us  = '0;
        sample_bus.sample_ok = 1'b0;
        sample_bus.pos       = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero stamp, warm-up, clamp at both extremes, unsmoothed output
        drive_sample(48'd0, 1'b1, random_pos());
        drive_sample(48'd1000, 1'b1, '0);
        drive_sample(48'd2000, 1'b1, {POS_MAX, POS_MIN, POS_MAX, POS_MIN, 32'd1, 32'hFFFF_FFFF});
        drive_sample(48'd3000, 1'b1, {POS_MIN, POS_MAX, POS_MIN, POS_MAX, 32'd0, 32'd0});
        drive_sample(48'd4000, 1'b1, {32'h8000_0064, 32'h7FFF_FF9B, 32'h8000_0005,
                                      32'h7FFF_FFFA, 32'd1000, 32'hFFFF_FC18});
        // flagged sample, gap exactly at the limit, gap just over it
        drive_sample(48'd5000, 1'b0, random_pos());
        drive_sample(48'd5001, 1'b1, '0);
        drive_sample(48'd5002, 1'b1, {6{32'd100}});
        drive_sample(48'd105002, 1'b1, {6{32'hFFFF_0000}});
        drive_sample(48'd205003, 1'b1, '0);
        // repeated stamp, then stamp going backward
        drive_sample(48'd300000, 1'b1, random_pos());
        drive_sample(48'd300001, 1'b1, random_pos());
        drive_sample(48'd300001, 1'b1, random_pos());
        drive_sample(48'd400000, 1'b1, random_pos());
        drive_sample(48'd400010, 1'b1, random_pos());
        drive_sample(48'd400005, 1'b1, random_pos());
        // top of the stamp range, then the smallest gap
        drive_sample(48'hFFFF_FFFF_FFFF, 1'b1, random_pos());
        drive_sample(48'hFFFF_FFFF_FFFE, 1'b1, random_pos());
        drive_sample(48'd1, 1'b1, random_pos());
        drive_sample(48'd2, 1'b1, random_pos());
        drive_sample(48'd3, 1'b1, random_pos());

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            wait_drained();
            apply_setting(ph);
            idle_on = (ph != 4);
            run_phase();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && estimates_due == 0)
            $display("** joint_velocity_estimator_core: PASSED **");
        else
            $display("** joint_velocity_estimator_core: FAILED **");
        $finish;
    end

    initial
    begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (sample_bus.valid && sample_bus.ready)
                || (estimate_bus.valid && estimate_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("** joint_velocity_estimator_core: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/jve_pkg.sv
hdl/jve_cfg_if.sv
hdl/jve_sample_if.sv
hdl/jve_estimate_if.sv
hdl/jve_lane.sv
hdl/jve_ctrl.sv
hdl/jve_merge.sv
hdl/joint_velocity_estimator_core.sv
sim/jve_checker.sv
sim/tb.sv
